[src/plst_pkg.sv]
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types and constants of the positional list store.
// ----------------------------------------------------------------------------
package plst_pkg;

  localparam int CAPACITY    = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 6;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 48;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_SHOW      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_END   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_END   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd6;

  // status codes on the result channel
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

  typedef enum logic [1:0] {
    KIND_SHOW,
    KIND_INSERT,
    KIND_DELETE,
    KIND_BAD
  } plst_kind_t;

  typedef enum logic [1:0] {
    WHERE_FRONT,
    WHERE_END,
    WHERE_AT
  } plst_where_t;

  typedef struct packed {
    plst_kind_t           kind;
    plst_where_t          where;
    logic [VALUE_W-1:0]   value;
    logic [POS_W-1:0]     position;
  } plst_cmd_t;

endpackage

[src/positional_list_store.sv]
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed 32-bit values with positional insert and delete.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream (command, value, position in s_tdata) and
// results leave on the m_ stream (status, element, element_index and
// entry_count in m_tdata, m_tlast on the final result of each command).
// A decode stage and a two-entry command queue sit in front of the list unit,
// so commands keep being taken while the list unit or the receiver stalls.
// Insert and delete shift the cells from the target position on together and
// give one status result each; commands pass the decode register and the queue
// first. The list unit retires one per cycle while the result register is free.
// Show enters the show state, then reads one entry per cycle from the cell
// array while the result register is free; an empty list gives one result.
// The result register holds its transaction while m_tready is low and the
// list unit waits; the queue then fills and s_tready drops.
// Reset (rst, synchronous) empties the list and drops all pending commands.
// ----------------------------------------------------------------------------
module positional_list_store
  import plst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // command[2:0], value[34:3], position[40:35]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // status[1:0], element[33:2],
                                           // element_index[39:34], entry_count[45:40]
  output logic                  m_tlast
);

  logic      f_valid;
  logic      f_ready;
  plst_cmd_t f_cmd;
  logic      b_valid;
  logic      b_ready;
  plst_cmd_t b_cmd;

  plst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_cmd    (f_cmd)
  );

  plst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_cmd   (b_cmd)
  );

  plst_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_cmd    (b_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

[src/plst_front.sv]
// ----------------------------------------------------------------------------
// plst_front
// Accepts commands and decodes them into kind and target before queueing.
// ----------------------------------------------------------------------------
module plst_front
  import plst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,   // command, value, position
  output logic                 q_valid,
  input  logic                 q_ready,
  output plst_cmd_t            q_cmd
);

  logic             valid;
  plst_cmd_t        cmd;
  plst_cmd_t        cmd_next;
  logic [CMD_W-1:0] code;

  assign code = s_tdata[CMD_W-1:0];

  always_comb begin
    cmd_next.value    = s_tdata[CMD_W+VALUE_W-1:CMD_W];
    cmd_next.position = s_tdata[CMD_W+VALUE_W+POS_W-1:CMD_W+VALUE_W];
    cmd_next.kind     = KIND_BAD;
    cmd_next.where    = WHERE_AT;
    case (code)
      CMD_SHOW:      begin cmd_next.kind = KIND_SHOW;   cmd_next.where = WHERE_FRONT; end
      CMD_INS_FRONT: begin cmd_next.kind = KIND_INSERT; cmd_next.where = WHERE_FRONT; end
      CMD_INS_END:   begin cmd_next.kind = KIND_INSERT; cmd_next.where = WHERE_END;   end
      CMD_INS_AT:    begin cmd_next.kind = KIND_INSERT; cmd_next.where = WHERE_AT;    end
      CMD_DEL_FRONT: begin cmd_next.kind = KIND_DELETE; cmd_next.where = WHERE_FRONT; end
      CMD_DEL_END:   begin cmd_next.kind = KIND_DELETE; cmd_next.where = WHERE_END;   end
      CMD_DEL_AT:    begin cmd_next.kind = KIND_DELETE; cmd_next.where = WHERE_AT;    end
      default:       begin cmd_next.kind = KIND_BAD;    cmd_next.where = WHERE_AT;    end
    endcase
  end

  assign s_tready = !valid || q_ready;
  assign q_valid  = valid;
  assign q_cmd    = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (q_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= cmd_next;
    end
  end

endmodule

[src/plst_queue.sv]
// ----------------------------------------------------------------------------
// plst_queue
// Short command queue between the decode stage and the list unit.
// ----------------------------------------------------------------------------
module plst_queue
  import plst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  plst_cmd_t in_cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output plst_cmd_t out_cmd
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  plst_cmd_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic              pop;

  assign in_ready  = (fill != FILL_W'(QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

[src/plst_back.sv]
// ----------------------------------------------------------------------------
// plst_back
// List cells, shift-based insert and delete, show streaming, result register.
// ----------------------------------------------------------------------------
module plst_back
  import plst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  plst_cmd_t             q_cmd,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // status, element, element_index, entry_count
  output logic                  m_tlast
);

  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic {
    ST_IDLE,
    ST_SHOW
  } state_t;

  state_t              state;
  logic [VALUE_W-1:0]  cells [CAPACITY];
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    show_idx;

  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  element;
  logic [POS_W-1:0]    element_index;
  logic [POS_W-1:0]    entry_count;
  logic                last;

  logic                out_free;
  logic                pop;
  logic                show_emit;
  logic                start_show;
  logic                load;
  logic                do_ins;
  logic                do_del;
  logic [IDX_W-1:0]    cell_p;
  logic [CMP_W-1:0]    cnt_ext;
  logic [CMP_W-1:0]    pos_ext;
  logic                pos_zero;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    show_num;

  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0]  res_element;
  logic [CNT_W-1:0]    res_index;
  logic                res_last;

  assign out_free  = !m_tvalid || m_tready;
  assign q_ready   = (state == ST_IDLE) && out_free;
  assign pop       = q_valid && q_ready;
  assign show_emit = (state == ST_SHOW) && out_free;
  assign cnt_ext   = CMP_W'(count);
  assign pos_ext   = CMP_W'(q_cmd.position);
  assign pos_zero  = (q_cmd.position == '0);
  assign show_num  = CNT_W'(show_idx) + 1'b1;

  always_comb begin
    do_ins      = 1'b0;
    do_del      = 1'b0;
    start_show  = 1'b0;
    cell_p      = '0;
    res_status  = STATUS_OK;
    res_element = '0;
    res_index   = '0;
    res_last    = 1'b1;
    count_next  = count;
    if (state == ST_SHOW) begin
      res_element = cells[show_idx];
      res_index   = show_num;
      res_last    = (show_num == count);
    end else begin
      case (q_cmd.kind)
        KIND_SHOW: begin
          if (count == '0) begin
            res_status = STATUS_EMPTY;
          end else begin
            start_show = pop;
          end
        end
        KIND_INSERT: begin
          case (q_cmd.where)
            WHERE_FRONT: cell_p = '0;
            WHERE_END:   cell_p = IDX_W'(count);
            default:     cell_p = IDX_W'(pos_ext - 1'b1);
          endcase
          if (count >= CNT_W'(CAPACITY)) begin
            res_status = STATUS_FULL;
          end else if (q_cmd.where == WHERE_AT &&
                       (pos_zero || pos_ext > cnt_ext + 1'b1)) begin
            res_status = STATUS_BADPOS;
          end else begin
            do_ins     = pop;
            count_next = count + 1'b1;
          end
        end
        KIND_DELETE: begin
          case (q_cmd.where)
            WHERE_FRONT: cell_p = '0;
            WHERE_END:   cell_p = IDX_W'(count - 1'b1);
            default:     cell_p = IDX_W'(pos_ext - 1'b1);
          endcase
          if (count == '0) begin
            res_status = STATUS_EMPTY;
          end else if (q_cmd.where == WHERE_AT && (pos_zero || pos_ext > cnt_ext)) begin
            res_status = STATUS_BADPOS;
          end else begin
            do_del     = pop;
            count_next = count - 1'b1;
          end
        end
        default: res_status = STATUS_BADPOS;
      endcase
    end
  end

  assign load = show_emit || (pop && !start_show);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      show_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        count <= count_next;
      end
      case (state)
        ST_IDLE: begin
          if (start_show) begin
            state    <= ST_SHOW;
            show_idx <= '0;
          end
        end
        ST_SHOW: begin
          if (show_emit) begin
            if (res_last) begin
              state <= ST_IDLE;
            end
            show_idx <= show_idx + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      status        <= res_status;
      element       <= res_element;
      element_index <= POS_W'(res_index);
      entry_count   <= POS_W'(count_next);
      last          <= res_last;
    end
  end

  // cells from the target position on shift towards their neighbour together
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (IDX_W'(g) == cell_p) begin
          cells[g] <= q_cmd.value;
        end else if (g > 0 && IDX_W'(g) > cell_p) begin
          cells[g] <= cells[(g > 0) ? g - 1 : 0];
        end
      end else if (do_del) begin
        if (g < CAPACITY - 1 && IDX_W'(g) >= cell_p) begin
          cells[g] <= cells[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end
    end
  end

  assign m_tdata = {2'b00, entry_count, element_index, element, status};
  assign m_tlast = last;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_show_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHOW |-> CNT_W'(show_idx) < count)
    else $error("show index past end of list");

  a_status_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != STATUS_OK |-> element == '0 && element_index == '0 && last)
    else $error("status result carries entry payload");

  a_no_pop_in_show: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHOW |-> !q_ready)
    else $error("command taken while streaming the list");
`endif

endmodule

[verif/positional_list_store_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_tb
// Self-checking bench for the positional list store.
// ----------------------------------------------------------------------------
// Commands are queued up front and driven on the s_ stream, with random
// idle bursts on both streams. Each accepted command goes through a local
// model of the list, and every m_ transaction is checked against the oldest
// result still due. The directed part covers the empty list, bad positions
// and the unused code. The random part fills the list to capacity, tries
// inserts on the full list, mixes commands, then drains the list back to empty.
// ----------------------------------------------------------------------------
module positional_list_store_tb;
  import plst_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int QUIET_TAIL  = 25;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  element;
    logic [5:0]          index;
    logic [5:0]          count;
    logic                last;
  } list_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // command[2:0], value[34:3], position[40:35]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // status[1:0], element[33:2],
                                         // element_index[39:34], entry_count[45:40]
  logic                  m_tlast;

  logic [IN_DATA_W-1:0] pending_cmds[$];
  list_result_t         due_results[$];

  // local copy of the list contents
  logic [VALUE_W-1:0] list_cells[CAPACITY];
  int                 list_len = 0;

  int  gen_len = 0;
  bit  quiet = 1'b0;
  bit  s_taken = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  idle_cycles = 0;
  int  mismatches = 0;

  positional_list_store dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  task automatic push_status(input logic [STATUS_W-1:0] st);
    list_result_t r;
    r = '0;
    r.status = st;
    r.count = list_len[5:0];
    r.last = 1'b1;
    due_results.push_back(r);
  endtask

  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                               input logic [POS_W-1:0] pos);
    list_result_t r;
    int slot;
    if (cmd == CMD_SHOW) begin
      if (list_len == 0) begin
        push_status(STATUS_EMPTY);
      end else begin
        for (int i = 0; i < list_len; i++) begin
          r.status = STATUS_OK;
          r.element = list_cells[i];
          r.index = 6'(i + 1);
          r.count = list_len[5:0];
          r.last = (i + 1 == list_len);
          due_results.push_back(r);
        end
      end
    end else if (cmd == CMD_INS_FRONT || cmd == CMD_INS_END || cmd == CMD_INS_AT) begin
      slot = (cmd == CMD_INS_FRONT) ? 0 : (cmd == CMD_INS_END) ? list_len : int'(pos) - 1;
      if (list_len >= CAPACITY) begin
        push_status(STATUS_FULL);
      end else if (cmd == CMD_INS_AT && (pos == 0 || pos > list_len + 1)) begin
        push_status(STATUS_BADPOS);
      end else begin
        for (int i = list_len; i > slot; i--) list_cells[i] = list_cells[i-1];
        list_cells[slot] = val;
        list_len++;
        push_status(STATUS_OK);
      end
    end else if (cmd == CMD_DEL_FRONT || cmd == CMD_DEL_END || cmd == CMD_DEL_AT) begin
      slot = (cmd == CMD_DEL_FRONT) ? 0 : (cmd == CMD_DEL_END) ? list_len - 1 : int'(pos) - 1;
      if (list_len == 0) begin
        push_status(STATUS_EMPTY);
      end else if (cmd == CMD_DEL_AT && (pos == 0 || pos > list_len)) begin
        push_status(STATUS_BADPOS);
      end else begin
        for (int i = slot; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
        list_len--;
        push_status(STATUS_OK);
      end
    end else begin
      push_status(STATUS_BADPOS);
    end
  endtask

  task automatic check_result();
    list_result_t got;
    list_result_t want;
    got.status = m_tdata[1:0];
    got.element = m_tdata[33:2];
    got.index = m_tdata[39:34];
    got.count = m_tdata[45:40];
    got.last = m_tlast;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: status %0d element %0d index %0d count %0d last %0d",
                 got.status, $signed(got.element), got.index, got.count, got.last);
    end else begin
      want = due_results.pop_front();
      if (got.status !== want.status || got.element !== want.element ||
          got.index !== want.index || got.count !== want.count || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: expected st %0d el %0d idx %0d cnt %0d last %0d, got st %0d el %0d idx %0d cnt %0d last %0d",
                   $realtime, want.status, $signed(want.element), want.index, want.count,
                   want.last, got.status, $signed(got.element), got.index, got.count,
                   got.last);
      end
    end
  endtask

  // monitor: predicts on command transactions, checks result transactions
  always @(posedge clk) begin
    s_taken <= s_tvalid && s_tready && !rst;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) apply_command(s_tdata[2:0], s_tdata[34:3], s_tdata[40:35]);
      if (m_tvalid && m_tready) check_result();
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // command driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_taken) begin
      // hold until the transaction goes through
    end else if (in_gap > 0) begin
      in_gap--;
      s_tvalid <= 1'b0;
    end else if (pending_cmds.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
      in_gap = $urandom_range(0, 18);
      s_tvalid <= 1'b0;
    end else if (pending_cmds.size() != 0) begin
      s_tvalid <= 1'b1;
      s_tdata <= pending_cmds.pop_front();
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // result receiver stalls
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 18);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // queue a command and track the length the list will have after it
  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    pending_cmds.push_back({7'b0, pos, val, cmd});
    case (cmd)
      CMD_INS_FRONT, CMD_INS_END:
        if (gen_len < CAPACITY) gen_len++;
      CMD_INS_AT:
        if (gen_len < CAPACITY && pos != 0 && pos <= gen_len + 1) gen_len++;
      CMD_DEL_FRONT, CMD_DEL_END:
        if (gen_len > 0) gen_len--;
      CMD_DEL_AT:
        if (gen_len > 0 && pos != 0 && pos <= gen_len) gen_len--;
      default: ;
    endcase
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] insert_pos(input int len);
    if ($urandom_range(0, 6) == 0)
      return $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(len + 2, 63));
    return 6'($urandom_range(1, len + 1));
  endfunction

  function automatic logic [POS_W-1:0] delete_pos(input int len);
    if (len == 0 || $urandom_range(0, 6) == 0)
      return $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(len + 1, 63));
    return 6'($urandom_range(1, len));
  endfunction

  task automatic queue_insert();
    case ($urandom_range(0, 2))
      0: queue_cmd(CMD_INS_FRONT, pick_value(), 6'($urandom_range(0, 63)));
      1: queue_cmd(CMD_INS_END, pick_value(), 6'($urandom_range(0, 63)));
      default: queue_cmd(CMD_INS_AT, pick_value(), insert_pos(gen_len));
    endcase
  endtask

  task automatic queue_delete();
    case ($urandom_range(0, 2))
      0: queue_cmd(CMD_DEL_FRONT, $urandom, 6'($urandom_range(0, 63)));
      1: queue_cmd(CMD_DEL_END, $urandom, 6'($urandom_range(0, 63)));
      default: queue_cmd(CMD_DEL_AT, $urandom, delete_pos(gen_len));
    endcase
  endtask

  initial begin
    logic [CMD_W-1:0] cmd;
    int roll;

    // directed: empty list, bad positions, unused code, value extremes
    queue_cmd(CMD_SHOW, 32'h0, 6'd0);
    queue_cmd(CMD_DEL_FRONT, 32'h0, 6'd0);
    queue_cmd(CMD_DEL_END, 32'h0, 6'd0);
    queue_cmd(CMD_DEL_AT, 32'h0, 6'd1);
    queue_cmd(CMD_INS_AT, 32'h1234_5678, 6'd0);
    queue_cmd(CMD_INS_AT, 32'h1234_5678, 6'd2);
    queue_cmd(CMD_UNUSED, 32'hffff_ffff, 6'd63);
    queue_cmd(CMD_INS_FRONT, 32'h7fff_ffff, 6'd0);
    queue_cmd(CMD_INS_END, 32'h8000_0000, 6'd63);
    queue_cmd(CMD_INS_AT, 32'h0000_0000, 6'd2);
    queue_cmd(CMD_INS_AT, 32'hffff_ffff, 6'd1);
    queue_cmd(CMD_INS_AT, 32'h5555_aaaa, 6'd63);
    queue_cmd(CMD_INS_AT, 32'h5555_aaaa, 6'd6);
    queue_cmd(CMD_SHOW, 32'h0, 6'd0);
    queue_cmd(CMD_DEL_AT, 32'h0, 6'd0);
    queue_cmd(CMD_DEL_AT, 32'h0, 6'd5);
    queue_cmd(CMD_DEL_AT, 32'h0, 6'd2);
    queue_cmd(CMD_DEL_FRONT, 32'h0, 6'd0);
    queue_cmd(CMD_DEL_END, 32'h0, 6'd0);
    queue_cmd(CMD_SHOW, 32'h0, 6'd0);
    queue_cmd(CMD_DEL_AT, 32'h0, 6'd1);
    queue_cmd(CMD_SHOW, 32'h0, 6'd0);

    // grow the list to capacity, with the odd show, delete or stray command
    while (gen_len < CAPACITY) begin
      roll = $urandom_range(0, 19);
      if (roll < 17) queue_insert();
      else if (roll == 17) queue_cmd(CMD_SHOW, $urandom, 6'($urandom_range(0, 63)));
      else if (roll == 18) queue_delete();
      else queue_cmd(CMD_UNUSED, $urandom, 6'($urandom_range(0, 63)));
    end
    // full list refuses every insert
    queue_cmd(CMD_INS_FRONT, pick_value(), 6'd0);
    queue_cmd(CMD_INS_END, pick_value(), 6'd0);
    queue_cmd(CMD_INS_AT, pick_value(), 6'($urandom_range(1, CAPACITY + 1)));
    queue_cmd(CMD_SHOW, 32'h0, 6'd0);

    // mixed commands around the full mark
    repeat (10) begin
      cmd = 3'($urandom_range(0, 7));
      if (cmd == CMD_INS_AT) queue_cmd(cmd, pick_value(), insert_pos(gen_len));
      else if (cmd == CMD_DEL_AT) queue_cmd(cmd, pick_value(), delete_pos(gen_len));
      else queue_cmd(cmd, pick_value(), 6'($urandom_range(0, 63)));
    end

    // drain back to empty
    while (gen_len > 0) begin
      roll = $urandom_range(0, 19);
      if (roll < 18) queue_delete();
      else if (roll == 18) queue_insert();
      else queue_cmd(CMD_SHOW, $urandom, 6'($urandom_range(0, 63)));
    end
    queue_delete();
    queue_cmd(CMD_SHOW, 32'h0, 6'd0);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    wait (pending_cmds.size() < QUIET_TAIL);
    quiet = 1'b1;
    while (pending_cmds.size() != 0 || s_tvalid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
src/plst_pkg.sv
src/plst_front.sv
src/plst_queue.sv
src/plst_back.sv
src/positional_list_store.sv
verif/positional_list_store_tb.sv
